// ===== rtl/pftbl_pkg.sv =====
// ----------------------------------------------------------------------------
// pftbl_pkg
// Shared constants and helpers for the per-flow token bucket limiter.
// ----------------------------------------------------------------------------
package pftbl_pkg;

  localparam int unsigned FLOWS_DEF     = 256;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned IDX_W     = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned RATE_W    = 24;
  localparam int unsigned BURST_W   = 16;
  localparam int unsigned CONN_W    = 16;
  localparam int unsigned RETRY_W   = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;
  localparam int unsigned SLOT_W    = 17;

  localparam logic [RATE_W-1:0]  RATE_RST  = 24'd218;
  localparam logic [BURST_W-1:0] BURST_RST = 16'd50;
  localparam logic [CONN_W-1:0]  LIMIT_RST = 16'd0;
  localparam logic [RETRY_W-1:0] RETRY_MAX = 17'h1FFFF;

  localparam logic [1:0] FN_CHECK = 2'd0;
  localparam logic [1:0] FN_OPEN  = 2'd1;
  localparam logic [1:0] FN_CLOSE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

  // flow index modulo slot count, one restoring step per index bit
  function automatic logic [SLOT_W-1:0] slot_of(logic [IDX_W-1:0] idx,
                                                int unsigned flows);
    logic [SLOT_W:0] r;
    logic [SLOT_W:0] f;
    r = '0;
    f = (SLOT_W+1)'(flows);
    for (int i = IDX_W - 1; i >= 0; i--) begin
      r = {r[SLOT_W-1:0], idx[i]};
      if (r >= f) begin
        r = r - f;
      end
    end
    return r[SLOT_W-1:0];
  endfunction

endpackage

// ===== rtl/per_flow_token_bucket_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// per_flow_token_bucket_limiter_unit
// Token bucket per flow slot with connection counting.
// ----------------------------------------------------------------------------
// One word at a time: a word is accepted only in the idle state and then
// passes the steps multiply, update and output; a request denied by the
// bucket with a nonzero refill rate also runs the bit-serial retry-time
// divider. The output step waits while an earlier result is not yet taken,
// and the next word can be accepted in the cycle the result appears. After reset
// a clearing pass writes the state memory before the first word is accepted.
module per_flow_token_bucket_limiter_unit #(
  parameter int unsigned FLOWS           = pftbl_pkg::FLOWS_DEF,
  parameter int unsigned TOKEN_FRAC_BITS = pftbl_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pftbl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pftbl_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_func,
  input  logic [pftbl_pkg::IDX_W-1:0]        in_flow_index,
  input  logic [pftbl_pkg::TIME_W-1:0]       in_time_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_deny,
  output logic [pftbl_pkg::RETRY_W-1:0]      out_retry_after
);

  localparam int unsigned AW     = $clog2(FLOWS);
  localparam int unsigned LVL_W  = pftbl_pkg::BURST_W + TOKEN_FRAC_BITS;
  localparam int unsigned TW     = pftbl_pkg::TIME_W;
  localparam int unsigned CW     = pftbl_pkg::CONN_W;
  localparam int unsigned ENT_W  = 1 + CW + TW + LVL_W;
  localparam int unsigned PROD_W = pftbl_pkg::RATE_W + TW;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned N_W    = TOKEN_FRAC_BITS + 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [LVL_W-1:0] ONE = LVL_W'(1) << TOKEN_FRAC_BITS;

  logic [2:0]                        state_r, state_nxt;
  logic [AW-1:0]                     clr_r, clr_nxt;
  logic [pftbl_pkg::RATE_W-1:0]      rate_r;
  logic [pftbl_pkg::BURST_W-1:0]     burst_r;
  logic [CW-1:0]                     limit_r;

  logic [1:0]                        func_r;
  logic [AW-1:0]                     slot_r;
  logic [TW-1:0]                     now_r;
  logic                              vld_r;
  logic [LVL_W-1:0]                  lvl_r;
  logic [TW-1:0]                     time_r;
  logic [CW-1:0]                     conns_r;
  logic [PROD_W-1:0]                 prod_r;
  logic                              deny_r, deny_nxt;
  logic [pftbl_pkg::RETRY_W-1:0]     retry_r, retry_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic                              out_deny_r;
  logic [pftbl_pkg::RETRY_W-1:0]     out_retry_r;

  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic [ENT_W-1:0]                  mem_wdata;
  logic [ENT_W-1:0]                  mem_rdata;
  logic [AW-1:0]                     slot_in;
  logic                              accept;

  logic                              rd_vld;
  logic [LVL_W-1:0]                  full_lvl;
  logic [LVL_W-1:0]                  t_lvl;
  logic [TW-1:0]                     t_time;
  logic [CW-1:0]                     t_conns;
  logic [TW-1:0]                     elapsed;

  logic [SUM_W-1:0]                  sum;
  logic [LVL_W-1:0]                  new_lvl;
  logic [LVL_W-1:0]                  wr_lvl;
  logic [TW-1:0]                     wr_time;
  logic [CW-1:0]                     wr_conns;
  logic                              calc_we;
  logic                              div_start;
  logic [N_W-1:0]                    div_num;
  logic                              div_done;
  logic [N_W-1:0]                    div_q;
  logic [31:0]                       q32;

  assign slot_in  = AW'(pftbl_pkg::slot_of(in_flow_index, FLOWS));
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full_lvl = LVL_W'(burst_r) << TOKEN_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= pftbl_pkg::RATE_RST;
      burst_r <= pftbl_pkg::BURST_RST;
      limit_r <= pftbl_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pftbl_pkg::REG_RATE:  rate_r  <= cfg_wdata[pftbl_pkg::RATE_W-1:0];
        pftbl_pkg::REG_BURST: burst_r <= cfg_wdata[pftbl_pkg::BURST_W-1:0];
        pftbl_pkg::REG_LIMIT: limit_r <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // entry as read, with creation applied
  always_comb begin
    rd_vld  = mem_rdata[ENT_W-1];
    t_conns = mem_rdata[ENT_W-2 -: CW];
    t_time  = mem_rdata[LVL_W +: TW];
    t_lvl   = mem_rdata[LVL_W-1:0];
    if (!rd_vld) begin
      t_conns = '0;
      t_time  = now_r;
      t_lvl   = full_lvl;
    end
    elapsed = now_r - t_time;
  end

  // update of the entry
  always_comb begin
    sum       = SUM_W'(prod_r) + SUM_W'(lvl_r);
    new_lvl   = (sum > SUM_W'(full_lvl)) ? full_lvl : sum[LVL_W-1:0];
    wr_lvl    = lvl_r;
    wr_time   = time_r;
    wr_conns  = conns_r;
    calc_we   = 1'b0;
    deny_nxt  = 1'b0;
    retry_nxt = '0;
    div_start = 1'b0;
    div_num   = N_W'(ONE - new_lvl);
    case (func_r)
      pftbl_pkg::FN_CHECK: begin
        calc_we = 1'b1;
        wr_time = now_r;
        if (new_lvl < ONE) begin
          deny_nxt = 1'b1;
          wr_lvl   = new_lvl;
          if (rate_r == '0) begin
            retry_nxt = pftbl_pkg::RETRY_MAX;
          end else begin
            div_start = (state_r == S_CALC);
          end
        end else begin
          wr_lvl = new_lvl - ONE;
        end
      end
      pftbl_pkg::FN_OPEN: begin
        if (limit_r != '0) begin
          calc_we = 1'b1;
          if (conns_r >= limit_r) begin
            deny_nxt = 1'b1;
          end else begin
            wr_conns = conns_r + 1'b1;
          end
        end
      end
      pftbl_pkg::FN_CLOSE: begin
        if (vld_r && conns_r != '0) begin
          calc_we  = 1'b1;
          wr_conns = conns_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_r;
    mem_wdata = {1'b1, wr_conns, wr_time, wr_lvl};
    if (state_r == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (state_r == S_CALC) begin
      mem_we = calc_we;
    end
  end

  assign q32 = 32'(div_q);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(FLOWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_CALC;
      S_CALC: state_nxt = div_start ? S_DIV : S_FIN;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      slot_r <= slot_in;
      now_r  <= in_time_ms;
    end
    if (state_r == S_RD) begin
      vld_r   <= rd_vld;
      lvl_r   <= t_lvl;
      time_r  <= t_time;
      conns_r <= t_conns;
      prod_r  <= PROD_W'(rate_r) * PROD_W'(elapsed);
    end
    if (state_r == S_CALC) begin
      deny_r  <= deny_nxt;
      retry_r <= retry_nxt;
    end
    if (state_r == S_DIV && div_done) begin
      retry_r <= (q32 > 32'(pftbl_pkg::RETRY_MAX)) ? pftbl_pkg::RETRY_MAX
                                                   : q32[pftbl_pkg::RETRY_W-1:0];
    end
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_deny_r  <= deny_r;
      out_retry_r <= retry_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_deny        = out_deny_r;
  assign out_retry_after = out_retry_r;

  pftbl_mem #(
    .DEPTH (FLOWS),
    .AW    (AW),
    .W     (ENT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (slot_in),
    .rdata (mem_rdata)
  );

  pftbl_div #(
    .N_W (N_W),
    .D_W (pftbl_pkg::RATE_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_num),
    .denom (rate_r),
    .done  (div_done),
    .quot  (div_q)
  );

endmodule

// ===== rtl/pftbl_mem.sv =====
// ----------------------------------------------------------------------------
// pftbl_mem
// Per-flow state memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module pftbl_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned W     = 81
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pftbl_div.sv =====
// ----------------------------------------------------------------------------
// pftbl_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pftbl_div #(
  parameter int unsigned N_W = 17,
  parameter int unsigned D_W = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] numer,
  input  logic [D_W-1:0] denom,
  output logic           done,
  output logic [N_W-1:0] quot
);

  localparam int unsigned CW = $clog2(N_W + 1);

  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [N_W-1:0] q_r, q_nxt;
  logic [D_W:0]   rem_r, rem_nxt;
  logic [D_W-1:0] den_r, den_nxt;
  logic [D_W:0]   sh;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    sh       = {rem_r[D_W-1:0], q_r[N_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(N_W);
      q_nxt    = numer;
      rem_nxt  = '0;
      den_nxt  = denom;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt   = {q_r[N_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[N_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== sim/tb_per_flow_token_bucket_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_per_flow_token_bucket_limiter_unit
// Drives request checks and connection open/close words through the limiter
// under several rate, burst and limit settings, predicts each deny flag and
// retry time from a per-flow token bucket kept in the bench, and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_per_flow_token_bucket_limiter_unit;
  import pftbl_pkg::*;

  localparam logic [1:0] FN_SPARE = 2'd3;
  localparam int unsigned SETTLE = 40;
  localparam int unsigned WATCH_LIMIT = 20000;
  localparam logic [63:0] ONE_TOKEN = 64'd1 << FRAC_BITS_DEF;

  typedef struct {
    logic [1:0]        func;
    logic [IDX_W-1:0]  flow;
    logic [TIME_W-1:0] stamp;
  } word_t;

  typedef struct {
    logic               deny;
    logic [RETRY_W-1:0] retry;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_func = '0;
  logic [IDX_W-1:0] in_flow_index = '0;
  logic [TIME_W-1:0] in_time_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_deny;
  logic [RETRY_W-1:0] out_retry_after;

  per_flow_token_bucket_limiter_unit dut (.*);

  // bucket model
  logic [RATE_W-1:0]  rate_q = RATE_RST;
  logic [BURST_W-1:0] burst_q = BURST_RST;
  logic [CONN_W-1:0]  limit_q = LIMIT_RST;
  logic [63:0]        fill_q [FLOWS_DEF];
  logic [TIME_W-1:0]  stamp_q [FLOWS_DEF];
  logic [CONN_W-1:0]  conns_q [FLOWS_DEF];
  logic               live_q [FLOWS_DEF];

  word_t    pending [$];
  verdict_t verdicts [$];
  int errs = 0, n_in = 0, n_out = 0, n_deny = 0, idle_cnt = 0, gap = 0, stall = 0;
  logic took = 1'b0, calm = 1'b0;
  logic [TIME_W-1:0] now_ms = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void open_entry(int s, logic [TIME_W-1:0] t);
    if (!live_q[s]) begin
      live_q[s] = 1'b1;
      fill_q[s] = 64'(burst_q) << FRAC_BITS_DEF;
      stamp_q[s] = t;
      conns_q[s] = '0;
    end
  endfunction

  function automatic verdict_t bucket_verdict(word_t w);
    verdict_t v;
    int s;
    logic [TIME_W-1:0] dt;
    logic [63:0] lvl, cap, q;
    v.deny = 1'b0;
    v.retry = '0;
    s = int'(w.flow);
    cap = 64'(burst_q) << FRAC_BITS_DEF;
    case (w.func)
      FN_CHECK: begin
        open_entry(s, w.stamp);
        dt = w.stamp - stamp_q[s];
        lvl = fill_q[s] + 64'(rate_q) * 64'(dt);
        if (lvl > cap) lvl = cap;
        stamp_q[s] = w.stamp;
        if (lvl < ONE_TOKEN) begin
          v.deny = 1'b1;
          if (rate_q == 0) begin
            v.retry = RETRY_MAX;
          end else begin
            q = (ONE_TOKEN - lvl) / 64'(rate_q);
            v.retry = (q > 64'(RETRY_MAX)) ? RETRY_MAX : q[RETRY_W-1:0];
          end
        end else begin
          lvl = lvl - ONE_TOKEN;
        end
        fill_q[s] = lvl;
      end
      FN_OPEN: begin
        if (limit_q != 0) begin
          open_entry(s, w.stamp);
          if (conns_q[s] >= limit_q) v.deny = 1'b1;
          else conns_q[s] = conns_q[s] + 1'b1;
        end
      end
      FN_CLOSE: begin
        if (live_q[s] && conns_q[s] > 0) conns_q[s] = conns_q[s] - 1'b1;
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  // accept side and prediction
  always @(posedge clk) begin
    took <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      word_t w;
      w.func = in_func;
      w.flow = in_flow_index;
      w.stamp = in_time_ms;
      verdicts.push_back(bucket_verdict(w));
      n_in++;
    end
  end

  // word driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !took)) begin
      if (gap > 0) begin
        gap--;
        in_valid <= 1'b0;
      end else if (pending.size() > 0) begin
        word_t w;
        w = pending.pop_front();
        in_func <= w.func;
        in_flow_index <= w.flow;
        in_time_ms <= w.stamp;
        in_valid <= 1'b1;
        gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (stall > 0) begin
      stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall = pick_gap();
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_out++;
      if (verdicts.size() == 0) begin
        $error("unexpected result word: deny %0d retry %0d", out_deny, out_retry_after);
        errs++;
      end else begin
        verdict_t v;
        v = verdicts.pop_front();
        if (v.deny) n_deny++;
        if (out_deny !== v.deny) begin
          $error("deny: expected %0d, got %0d", v.deny, out_deny);
          errs++;
        end
        if (out_retry_after !== v.retry) begin
          $error("retry_after: expected %0d, got %0d", v.retry, out_retry_after);
          errs++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCH_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCH_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_RATE: rate_q = val[RATE_W-1:0];
      REG_BURST: burst_q = val[BURST_W-1:0];
      REG_LIMIT: limit_q = val[CONN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic put(logic [1:0] f, logic [IDX_W-1:0] fl, logic [TIME_W-1:0] t);
    word_t w;
    w.func = f;
    w.flow = fl;
    w.stamp = t;
    pending.push_back(w);
  endtask

  task automatic drain();
    wait (pending.size() == 0 && !in_valid && verdicts.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_words(int n);
    int r;
    logic [1:0] f;
    logic [IDX_W-1:0] fl;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      f = (r < 55) ? FN_CHECK : (r < 75) ? FN_OPEN : (r < 95) ? FN_CLOSE : FN_SPARE;
      r = $urandom_range(99);
      fl = (r < 70) ? IDX_W'($urandom_range(7)) : (r < 80) ? 8'hFF : IDX_W'($urandom);
      r = $urandom_range(99);
      if (r < 50) now_ms = now_ms;
      else if (r < 85) now_ms = now_ms + $urandom_range(20);
      else if (r < 95) now_ms = now_ms + $urandom_range(5000);
      else if (r < 98) now_ms = $urandom;
      else now_ms = now_ms - $urandom_range(1000);
      put(f, fl, now_ms);
    end
  endtask

  initial begin
    logic [CFG_DAT_W-1:0] rv;
    int r;
    for (int i = 0; i < FLOWS_DEF; i++) begin
      live_q[i] = 1'b0;
      fill_q[i] = '0;
      stamp_q[i] = '0;
      conns_q[i] = '0;
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: new flows, wrap, backwards time, unlimited open, spare code
    put(FN_CHECK, 8'd0, 32'd0);
    put(FN_CHECK, 8'hFF, 32'hFFFF_FFFF);
    put(FN_CHECK, 8'hFF, 32'd0);
    put(FN_CHECK, 8'hFF, 32'd100);
    put(FN_CHECK, 8'hFF, 32'd50);
    put(FN_OPEN, 8'd1, 32'd50);
    put(FN_CLOSE, 8'd1, 32'd50);
    put(FN_CLOSE, 8'd2, 32'd50);
    put(FN_SPARE, 8'd3, 32'd50);
    drain();

    // zero rate, tiny burst, limit of two
    write_reg(REG_RATE, 24'd0);
    write_reg(REG_BURST, 24'd2);
    write_reg(REG_LIMIT, 24'd2);
    for (int i = 0; i < 4; i++) put(FN_CHECK, 8'd9, 32'd60);
    for (int i = 0; i < 3; i++) put(FN_OPEN, 8'd9, 32'd60);
    for (int i = 0; i < 3; i++) put(FN_CLOSE, 8'd9, 32'd60);
    put(FN_OPEN, 8'd9, 32'd61);
    drain();

    // empty bucket: slowest and fastest refill, widest limit
    write_reg(REG_RATE, 24'd1);
    write_reg(REG_BURST, 24'd0);
    write_reg(REG_LIMIT, 24'hFFFF);
    put(FN_CHECK, 8'd20, 32'd70);
    put(FN_CHECK, 8'd20, 32'd90000);
    put(FN_OPEN, 8'd20, 32'd90000);
    drain();
    write_reg(REG_RATE, 24'hFF_FFFF);
    put(FN_CHECK, 8'd21, 32'd100);
    put(FN_CHECK, 8'd20, 32'hFFFF_FFF0);
    drain();

    now_ms = 32'd100000;
    for (int p = 0; p < 8; p++) begin
      calm = (p == 3);
      r = $urandom_range(9);
      rv = (r < 2) ? 24'd1 : (r < 7) ? 24'($urandom_range(20000)) : (r < 9) ? 24'($urandom)
         : 24'hFF_FFFF;
      write_reg(REG_RATE, rv);
      r = $urandom_range(9);
      rv = (r < 7) ? 24'($urandom_range(4, 1)) : (r < 9) ? 24'hFFFF : 24'd0;
      write_reg(REG_BURST, rv);
      r = $urandom_range(9);
      rv = (r < 3) ? 24'd0 : (r < 8) ? 24'($urandom_range(3, 1)) : 24'hFFFF;
      write_reg(REG_LIMIT, rv);
      random_words(50);
      drain();
    end

    $display("covered %0d words and %0d results (%0d denied) over 12 register settings",
             n_in, n_out, n_deny);
    if (errs == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d field mismatches", errs);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
